### design/assert_macros.svh
// Assertion macros shared by the engine modules.
// Depends on a clock named clk and a reset named rst in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, checked outside reset.
`define ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### design/hsha_pkg.sv
// Shared types, states and SHA-256 constants for the HMAC-SHA256 engine.
// No dependencies.
package hsha_pkg;

  typedef struct packed {
    logic       last;
    logic       byte_valid;
    logic [7:0] msg_byte;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_BYTE, ST_PMARK, ST_PZERO, ST_PLEN, ST_OKEY, ST_ODIG, ST_OUT, ST_COMP
  } state_t;

  localparam logic [7:0]  INNER_XOR = 8'h36;
  localparam logic [7:0]  OUTER_XOR = 8'h5c;
  localparam logic [7:0]  PAD_MARK  = 8'h80;
  localparam logic [5:0]  LEN_OFFSET = 6'd56;
  localparam logic [5:0]  LAST_SLOT = 6'd63;
  // Outer message is one pad block plus a 32-byte digest, counted in bits.
  localparam logic [63:0] OUTER_BITS = 64'd768;
  localparam int          QDEPTH = 4;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

### design/hsha_front.sv
// Input side: accepts items, drops idle ones and queues the rest.
// Depends on hsha_pkg.
module hsha_front import hsha_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tuser,
  input  logic       s_tlast,
  output logic       q_valid,
  input  logic       q_ready,
  output item_t      q_item
);

  item_t      queue [QDEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       push;
  logic       pop;

  assign s_tready = (count != 3'(QDEPTH));
  // An item with neither a byte nor an end mark changes nothing, so it is not queued.
  assign push = s_tvalid && s_tready && (s_tuser || s_tlast);
  assign q_valid = (count != 3'd0);
  assign pop = q_valid && q_ready;
  assign q_item = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {2'b0, push} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= '{last: s_tlast, byte_valid: s_tuser, msg_byte: s_tdata};
    end
  end

endmodule

### design/hsha_round.sv
// SHA-256 compression unit: one round per cycle over a rolling 16-word schedule.
// Depends on hsha_pkg.
module hsha_round import hsha_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [511:0] block,
  input  logic [31:0]  chain_in [8],
  output logic         done,
  output logic [31:0]  work [8]
);

  logic [31:0] w [16];
  logic [5:0]  t;
  logic        busy;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] w_new;

  always_comb begin
    t1 = work[7] + (rotr(work[4], 6) ^ rotr(work[4], 11) ^ rotr(work[4], 25))
       + ((work[4] & work[5]) ^ (~work[4] & work[6])) + ROUND_K[t] + w[0];
    t2 = (rotr(work[0], 2) ^ rotr(work[0], 13) ^ rotr(work[0], 22))
       + ((work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]));
    w_new = w[0] + (rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3)) + w[9]
          + (rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      t <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        t <= '0;
      end else if (busy) begin
        t <= t + 6'd1;
        if (t == LAST_SLOT) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < 8; i++) work[i] <= chain_in[i];
      for (int i = 0; i < 16; i++) w[i] <= block[511 - 32*i -: 32];
    end else if (busy) begin
      work[7] <= work[6];
      work[6] <= work[5];
      work[5] <= work[4];
      work[4] <= work[3] + t1;
      work[3] <= work[2];
      work[2] <= work[1];
      work[1] <= work[0];
      work[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
      w[15] <= w_new;
    end
  end

endmodule

### design/hsha_back.sv
// HMAC sequencer: key pads, message bytes, padding, outer hash and the tag register.
// Depends on hsha_pkg, hsha_round and assert_macros.svh.
`include "assert_macros.svh"
module hsha_back import hsha_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         q_valid,
  output logic         q_ready,
  input  item_t        q_item,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [255:0] m_tdata
);

  logic [63:0]  key [8];
  logic [511:0] key_blk;
  state_t       state, state_next;
  state_t       ret;
  item_t        item;
  logic [511:0] blk;
  logic [5:0]   fill;
  logic [63:0]  bytes_total;
  logic [63:0]  len_sr;
  logic [31:0]  chain [8];
  logic [255:0] inner;
  logic         pad_absorbed;
  logic         rnd_start;
  logic         rnd_done;
  logic [31:0]  work [8];

  hsha_round u_round (
    .clk(clk), .rst(rst), .start(rnd_start), .block(blk),
    .chain_in(chain), .done(rnd_done), .work(work)
  );

  assign key_blk = {key[0], key[1], key[2], key[3], key[4], key[5], key[6], key[7]};
  assign q_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) key[i] <= '0;
    end else if (cfg_we) begin
      key[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (q_valid) state_next = pad_absorbed ? ST_BYTE : ST_COMP;
      ST_BYTE:  begin
        if (item.byte_valid && fill == LAST_SLOT) state_next = ST_COMP;
        else state_next = item.last ? ST_PMARK : ST_IDLE;
      end
      ST_PMARK: state_next = (fill == LAST_SLOT) ? ST_COMP : ST_PZERO;
      ST_PZERO: begin
        if (fill == LEN_OFFSET) state_next = ST_PLEN;
        else if (fill == LAST_SLOT) state_next = ST_COMP;
      end
      ST_PLEN:  if (fill == LAST_SLOT) state_next = ST_COMP;
      ST_OKEY:  state_next = ST_COMP;
      ST_ODIG:  state_next = ST_COMP;
      ST_OUT:   if (!m_tvalid) state_next = ST_IDLE;
      ST_COMP:  if (rnd_done) state_next = ret;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) chain[i] <= INIT_H[i];
      fill <= '0;
      bytes_total <= '0;
      pad_absorbed <= 1'b0;
      rnd_start <= 1'b0;
      m_tvalid <= 1'b0;
      ret <= ST_IDLE;
    end else begin
      rnd_start <= (state_next == ST_COMP) && (state != ST_COMP);
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            item <= q_item;
            if (!pad_absorbed) begin
              for (int i = 0; i < 8; i++) chain[i] <= INIT_H[i];
              blk <= key_blk ^ {64{INNER_XOR}};
              bytes_total <= 64'd64;
              fill <= '0;
              pad_absorbed <= 1'b1;
              ret <= ST_BYTE;
            end
          end
        end
        ST_BYTE: begin
          if (item.byte_valid) begin
            blk <= {blk[503:0], item.msg_byte};
            bytes_total <= bytes_total + 64'd1;
            fill <= fill + 6'd1;
            ret <= item.last ? ST_PMARK : ST_IDLE;
          end
        end
        ST_PMARK: begin
          blk <= {blk[503:0], PAD_MARK};
          len_sr <= {bytes_total[60:0], 3'b000};
          fill <= fill + 6'd1;
          ret <= ST_PZERO;
        end
        ST_PZERO: begin
          if (fill != LEN_OFFSET) begin
            blk <= {blk[503:0], 8'h00};
            fill <= fill + 6'd1;
            ret <= ST_PZERO;
          end
        end
        ST_PLEN: begin
          blk <= {blk[503:0], len_sr[63:56]};
          len_sr <= {len_sr[55:0], 8'h00};
          fill <= fill + 6'd1;
          ret <= ST_OKEY;
        end
        ST_OKEY: begin
          inner <= {chain[0], chain[1], chain[2], chain[3],
                    chain[4], chain[5], chain[6], chain[7]};
          for (int i = 0; i < 8; i++) chain[i] <= INIT_H[i];
          blk <= key_blk ^ {64{OUTER_XOR}};
          ret <= ST_ODIG;
        end
        ST_ODIG: begin
          blk <= {inner, PAD_MARK, 184'b0, OUTER_BITS};
          ret <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_tvalid) begin
            m_tdata <= {chain[6], chain[7], chain[4], chain[5],
                        chain[2], chain[3], chain[0], chain[1]};
            m_tvalid <= 1'b1;
            for (int i = 0; i < 8; i++) chain[i] <= INIT_H[i];
            pad_absorbed <= 1'b0;
            fill <= '0;
            bytes_total <= '0;
          end
        end
        ST_COMP: begin
          if (rnd_done) begin
            for (int i = 0; i < 8; i++) chain[i] <= chain[i] + work[i];
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_NOW(a_done_in_comp, rnd_done, state == ST_COMP)
  `ASSERT_NEXT(a_tag_issued, state == ST_OUT && !m_tvalid, m_tvalid && !pad_absorbed)
  `ASSERT_NOW(a_len_slot, state == ST_PLEN, fill >= LEN_OFFSET)

endmodule

### design/hmac_sha256_engine_top.sv
// Top level of the HMAC-SHA256 engine.
// Depends on hsha_pkg, hsha_front and hsha_back.
//
// Usage: the 64-byte key is written through cfg_we/cfg_index/cfg_data while the
// engine is idle; register i holds key bytes 8i to 8i+7, the first in the top bits.
// Message bytes arrive on the s_ channel one item per handshake: tdata is the byte,
// tuser says the byte is real, tlast ends the message. An item with neither flag set
// is accepted and ignored. After the item with tlast the 256-bit tag appears on the
// m_ channel, tag byte 0 in bits 63:56 of the lowest 64-bit part.
// Each message byte is taken from the queue in the idle state and shifted into
// the block in the byte state, and a compression follows every 64 bytes. The
// compression unit runs one SHA-256 round a cycle. The first item of a message
// adds one compression for the inner key pad. The last item adds the padding and
// three or four compressions before the tag. A four-item queue lets the sender
// run ahead while the core is compressing. If the receiver stalls, the tag is
// held; the next message still proceeds until its own tag is ready. Reset clears
// the key to zero and restarts the hash state.
module hmac_sha256_engine_top import hsha_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // msg_byte
  input  logic         s_tuser,   // byte_valid
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [255:0] m_tdata    // tag_part_0, tag_part_1, tag_part_2, tag_part_3
);

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  hsha_front u_front (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tlast(s_tlast),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  hsha_back u_back (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

endmodule

### tb/sv/hmac_sha256_engine_checker.sv
// Tag checker for the HMAC-SHA256 engine: watches the key writes, the byte stream and the tag stream.
// It predicts each tag with its own SHA-256 and compares it with what the engine emits.
// Depends on hsha_pkg for the SHA-256 constants.
module hmac_sha256_engine_checker import hsha_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [7:0]   s_tdata,
  input  logic         s_tuser,
  input  logic         s_tlast,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [255:0] m_tdata,
  output int           fail_count,
  output int           tags_pending
);

  logic [63:0]  key_reg [8];
  logic [31:0]  chain [8];
  logic [7:0]   blk [64];
  logic [6:0]   fill;
  logic [63:0]  nbytes;
  logic         primed;
  logic [255:0] tag_queue [$];

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-7]
           + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endtask

  task automatic begin_hash();
    for (int i = 0; i < 8; i++) chain[i] = INIT_H[i];
    fill = '0;
    nbytes = '0;
  endtask

  task automatic absorb(input logic [7:0] b);
    blk[fill[5:0]] = b;
    fill = fill + 7'd1;
    nbytes = nbytes + 64'd1;
    if (fill >= 7'd64) begin
      compress_block();
      fill = '0;
    end
  endtask

  task automatic absorb_key(input logic [7:0] pad);
    for (int i = 0; i < 64; i++)
      absorb(key_reg[i/8][8*(7-i%8) +: 8] ^ pad);
  endtask

  // Standard SHA-256 tail: marker byte, zero fill, 64-bit big-endian bit count.
  task automatic close_hash();
    logic [63:0] bits;
    bits = nbytes << 3;
    blk[fill[5:0]] = PAD_MARK;
    fill = fill + 7'd1;
    if (fill > 7'd56) begin
      while (fill < 7'd64) begin blk[fill[5:0]] = 8'h00; fill = fill + 7'd1; end
      compress_block();
      fill = '0;
    end
    while (fill < 7'd56) begin blk[fill[5:0]] = 8'h00; fill = fill + 7'd1; end
    for (int i = 0; i < 8; i++) blk[56+i] = bits[8*(7-i) +: 8];
    compress_block();
    fill = '0;
  endtask

  task automatic take_item(input logic [7:0] b, input logic real_byte, input logic fin);
    logic [31:0]  inner [8];
    logic [255:0] tag;
    if (!real_byte && !fin) return;
    if (!primed) begin
      begin_hash();
      absorb_key(INNER_XOR);
      primed = 1'b1;
    end
    if (real_byte) absorb(b);
    if (!fin) return;
    close_hash();
    for (int i = 0; i < 8; i++) inner[i] = chain[i];
    begin_hash();
    absorb_key(OUTER_XOR);
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 4; j++) absorb(inner[i][8*(3-j) +: 8]);
    close_hash();
    for (int i = 0; i < 4; i++) tag[64*i +: 64] = {chain[2*i], chain[2*i+1]};
    tag_queue = {tag_queue, tag};
    begin_hash();
    primed = 1'b0;
  endtask

  always @(posedge clk) begin
    logic [255:0] want;
    if (rst) begin
      for (int i = 0; i < 8; i++) key_reg[i] = '0;
      begin_hash();
      primed = 1'b0;
      tag_queue.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) key_reg[cfg_index] = cfg_data;
      if (s_tvalid && s_tready) take_item(s_tdata, s_tuser, s_tlast);
      if (m_tvalid && m_tready) begin
        if (tag_queue.size() == 0) begin
          $display("%0t: tag with none expected: actual %h", $time, m_tdata);
          fail_count++;
        end else begin
          want = tag_queue.pop_front();
          for (int i = 0; i < 4; i++)
            if (m_tdata[64*i +: 64] !== want[64*i +: 64]) begin
              $display("%0t: tag part %0d expected %h actual %h", $time, i,
                       want[64*i +: 64], m_tdata[64*i +: 64]);
              fail_count++;
            end
        end
      end
    end
    tags_pending = tag_queue.size();
  end

endmodule

### tb/sv/hmac_sha256_engine_top_test.sv
// Top of the HMAC-SHA256 engine testbench: clock, reset, key writes, message stimulus, verdict.
// Depends on hsha_pkg, hmac_sha256_engine_top and hmac_sha256_engine_checker.
module hmac_sha256_engine_top_test;
  import hsha_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = '0;    // msg_byte
  logic         s_tuser = 1'b0;  // byte_valid
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [255:0] m_tdata;         // tag_part_0, tag_part_1, tag_part_2, tag_part_3

  int fail_count;
  int tags_pending;
  int items_sent = 0;
  int quiet_cycles;
  bit no_idle = 1'b0;

  // Cycles with no item moving on either channel before the run is called hung.
  // This leaves ample room for the slowest tag.
  localparam int HANG_LIMIT = 20000;

  hmac_sha256_engine_top dut (.*);

  hmac_sha256_engine_checker tag_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver holds off in about one cycle of six, except during the quiet stretch.
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= no_idle || ($urandom_range(99) >= 16);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one item and hold it until the engine takes it. Ready is sampled at the
  // falling edge, where it is settled, so the acceptance edge is known without races.
  task automatic send_item(input logic [7:0] b, input logic real_byte, input logic fin);
    bit took;
    while (!no_idle && $urandom_range(99) < 16) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= real_byte;
    s_tlast  <= fin;
    do begin
      @(negedge clk);
      took = s_tready;
      @(posedge clk);
    end while (!took);
    items_sent++;
  endtask

  // A message of n random bytes, with ignored items scattered in at random. The
  // closing item either carries the final byte or carries none.
  task automatic send_message(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      if (i == n - 1 && $urandom_range(1)) begin
        send_item(8'($urandom_range(255)), 1'b1, 1'b1);
        return;
      end
      send_item(8'($urandom_range(255)), 1'b1, 1'b0);
    end
    send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // Let the engine drain every tag, then write all eight key registers.
  // kind: 0 all zeros, 1 all ones, 2 fully random, 3 short random key, zero padded.
  task automatic load_key(input int kind);
    int used;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tags_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    used = $urandom_range(1, 7);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[2:0];
      case (kind)
        0: cfg_data <= '0;
        1: cfg_data <= '1;
        2: cfg_data <= {$urandom, $urandom};
        default: begin
          cfg_data <= (i < used) ? {$urandom, $urandom} : 64'd0;
        end
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int n, pick, msgs;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, first with the reset key of all zeros: the empty message, single bytes
    // at both extremes, ignored items before a message, and a message closed by an item
    // that carries no byte; then empty and one-byte messages under all-ones and random keys.
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h55, 1'b1, 1'b0);
    send_item(8'haa, 1'b1, 1'b1);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'hfe, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    load_key(1);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    load_key(2);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h7f, 1'b1, 1'b1);

    // Random part. Lengths cluster near the padding boundaries, where the length
    // field either fits in the final block or forces one more compression.
    msgs = 0;
    while (items_sent < 1850) begin
      no_idle = (items_sent > 700 && items_sent < 1000);
      if (msgs % 5 == 4) load_key($urandom_range(3));
      pick = $urandom_range(3);
      case (pick)
        0: n = $urandom_range(8);
        1: n = $urandom_range(50, 70);
        2: n = $urandom_range(120, 130);
        default: n = $urandom_range(130);
      endcase
      send_message(n);
      msgs++;
    end
    no_idle = 1'b0;
    s_tvalid <= 1'b0;

    while (tags_pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
